// File: rtl/crd_pkg.sv
// Shared widths, constants and the side-band record of the ray direction pipeline.
package crd_pkg;

   localparam int COMPS     = 3;
   localparam int MAG_W     = 31;
   localparam int SUM_W     = 64;
   localparam int LEN_W     = 32;
   localparam int QUO_W     = 15;
   localparam int DIR_W     = 16;
   localparam int UNIT_BITS = 14;
   localparam int REM_W     = MAG_W + UNIT_BITS + 1;

   typedef struct packed {
      logic                        degen;
      logic [COMPS-1:0]            neg;
      logic [COMPS-1:0][MAG_W-1:0] mag;
   } ray_side_type;

endpackage

// File: rtl/crd_isqrt.sv
// Pipelined integer square root, one root bit resolved in each stage.
module crd_isqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic [crd_pkg::SUM_W-1:0]        in_sum,
   input  crd_pkg::ray_side_type            in_side,
   output logic                             out_valid,
   output logic [crd_pkg::LEN_W-1:0]        out_root,
   output crd_pkg::ray_side_type            out_side
);

   localparam int STEPS = crd_pkg::SUM_W / 2;

   logic                        valid_ff [STEPS];
   logic [crd_pkg::SUM_W-1:0]   rem_ff   [STEPS];
   logic [crd_pkg::SUM_W-1:0]   root_ff  [STEPS];
   crd_pkg::ray_side_type       side_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [crd_pkg::SUM_W-1:0] STEP_BIT =
         crd_pkg::SUM_W'(1) << (crd_pkg::SUM_W - 2 - 2 * k);

      logic                      valid_src;
      logic [crd_pkg::SUM_W-1:0] rem_src;
      logic [crd_pkg::SUM_W-1:0] root_src;
      crd_pkg::ray_side_type     side_src;
      logic [crd_pkg::SUM_W-1:0] trial;
      logic [crd_pkg::SUM_W-1:0] rem_in;
      logic [crd_pkg::SUM_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = in_sum;
         assign root_src  = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign root_src  = root_ff[k-1];
         assign side_src  = side_ff[k-1];
      end

      always_comb begin
         trial = root_src + STEP_BIT;
         if (rem_src >= trial) begin
            rem_in  = rem_src - trial;
            root_in = (root_src >> 1) + STEP_BIT;
         end else begin
            rem_in  = rem_src;
            root_in = root_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_src;
         end
         if (advance) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1][crd_pkg::LEN_W-1:0];
   assign out_side  = side_ff[STEPS-1];

endmodule

// File: rtl/crd_div.sv
// Pipelined rounded division of the three magnitudes by the vector length.
module crd_div (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           advance,
   input  logic                                           in_valid,
   input  logic [crd_pkg::LEN_W-1:0]                      in_len,
   input  crd_pkg::ray_side_type                          in_side,
   output logic                                           out_valid,
   output logic [crd_pkg::COMPS-1:0][crd_pkg::QUO_W-1:0]  out_quo,
   output crd_pkg::ray_side_type                          out_side
);

   localparam int STEPS = crd_pkg::QUO_W;

   logic                                          valid_ff [STEPS];
   logic [crd_pkg::COMPS-1:0][crd_pkg::REM_W-1:0] rem_ff   [STEPS];
   logic [crd_pkg::COMPS-1:0][crd_pkg::QUO_W-1:0] quo_ff   [STEPS];
   logic [crd_pkg::LEN_W-1:0]                     len_ff   [STEPS];
   crd_pkg::ray_side_type                         side_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int SH = crd_pkg::QUO_W - 1 - k;

      logic                                          valid_src;
      logic [crd_pkg::COMPS-1:0][crd_pkg::REM_W-1:0] rem_src;
      logic [crd_pkg::COMPS-1:0][crd_pkg::QUO_W-1:0] quo_src;
      logic [crd_pkg::LEN_W-1:0]                     len_src;
      crd_pkg::ray_side_type                         side_src;
      logic [crd_pkg::REM_W-1:0]                     divisor;
      logic [crd_pkg::COMPS-1:0][crd_pkg::REM_W-1:0] rem_in;
      logic [crd_pkg::COMPS-1:0][crd_pkg::QUO_W-1:0] quo_in;

      if (k == 0) begin : g_first
         always_comb begin
            for (int i = 0; i < crd_pkg::COMPS; i++) begin
               rem_src[i] = (crd_pkg::REM_W'(in_side.mag[i]) << crd_pkg::UNIT_BITS)
                          + crd_pkg::REM_W'(in_len >> 1);
            end
         end
         assign valid_src = in_valid;
         assign quo_src   = '0;
         assign len_src   = in_len;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign quo_src   = quo_ff[k-1];
         assign len_src   = len_ff[k-1];
         assign side_src  = side_ff[k-1];
      end

      always_comb begin
         divisor = crd_pkg::REM_W'(len_src) << SH;
         for (int i = 0; i < crd_pkg::COMPS; i++) begin
            quo_in[i] = quo_src[i];
            if (rem_src[i] >= divisor) begin
               rem_in[i]     = rem_src[i] - divisor;
               quo_in[i][SH] = 1'b1;
            end else begin
               rem_in[i] = rem_src[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_src;
         end
         if (advance) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            len_ff[k]  <= len_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// File: rtl/camera_ray_direction_core.sv
// Pinhole camera ray generation: image coordinate in, unit ray direction out.
// One item is taken every cycle unless a stalled response holds the pipeline.
// The depth is set by the 32-stage square root and the 15-stage divider behind ten
// stages of scaling, rotation and squaring.
// A stalled response holds the whole pipeline. Synchronous reset clears all valid
// bits and loads the identity orientation, unit focal length and aspect, zero origin.
module camera_ray_direction_core #(
   parameter int COORD_FRAC_BITS = 15
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [15:0]         req_u,
   input  logic [15:0]         req_v,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_dir_x,
   output logic signed [15:0]  rsp_dir_y,
   output logic signed [15:0]  rsp_dir_z,
   output logic [47:0]         rsp_ray_origin,
   output logic                rsp_degenerate,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [47:0]         csr_data
);

   localparam int PX_W  = ((COORD_FRAC_BITS > 17) ? COORD_FRAC_BITS : 17) + 2;
   localparam int V_W   = PX_W + 18;
   localparam int VS_W  = 26;
   localparam int C_W   = 43;
   localparam int CC_W  = 60;
   localparam int R_W   = 64;
   localparam int SQ_W  = 2 * crd_pkg::MAG_W;
   localparam int PRE_LIMIT  = 24;
   localparam int POST_LIMIT = 30;
   localparam int ROT_SHIFT  = 28;

   typedef enum logic [2:0] {
      REG_QUAT_W, REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z,
      REG_FOCAL, REG_ASPECT, REG_ORIGIN
   } csr_index_type;

   function automatic logic [6:0] bit_len(input logic [63:0] x);
      logic [6:0] len;
      len = '0;
      for (int i = 0; i < 64; i++) begin
         if (x[i]) begin
            len = 7'(i + 1);
         end
      end
      return len;
   endfunction

   logic signed [15:0] quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   logic [15:0]        focal_ff, aspect_ff;
   logic [47:0]        origin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_w_ff <= 16'sd16384;
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
         focal_ff  <= 16'd256;
         aspect_ff <= 16'd256;
         origin_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            REG_QUAT_W: quat_w_ff <= $signed(csr_data[15:0]);
            REG_QUAT_X: quat_x_ff <= $signed(csr_data[15:0]);
            REG_QUAT_Y: quat_y_ff <= $signed(csr_data[15:0]);
            REG_QUAT_Z: quat_z_ff <= $signed(csr_data[15:0]);
            REG_FOCAL:  focal_ff  <= csr_data[15:0];
            REG_ASPECT: aspect_ff <= csr_data[15:0];
            REG_ORIGIN: origin_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic        advance;
   logic        rsp_valid_ff;
   logic [10:1] pv_ff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign advance   = ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (advance) begin
         pv_ff <= {pv_ff[9:1], req_valid};
      end
   end

   // Stage 1: local plane vector.
   logic signed [PX_W-1:0] px, py;
   logic signed [V_W-1:0]  v1_in [3];
   logic signed [V_W-1:0]  v1_ff [3];

   always_comb begin
      px = $signed(PX_W'({req_u, 1'b0})) - $signed(PX_W'(1) << COORD_FRAC_BITS);
      py = $signed(PX_W'({req_v, 1'b0})) - $signed(PX_W'(1) << COORD_FRAC_BITS);
      v1_in[0] = -(V_W'(px) * $signed(V_W'({1'b0, aspect_ff})));
      v1_in[1] = -(V_W'(py) <<< 8);
      v1_in[2] = $signed(V_W'(focal_ff) << COORD_FRAC_BITS);
   end

   // Stage 2: pre-scale amount.
   logic [V_W-1:0] v_or;
   logic [6:0]     bl1;
   logic [6:0]     s1_in, s1_ff;
   logic signed [V_W-1:0] v2_ff [3];

   always_comb begin
      v_or = '0;
      for (int i = 0; i < 3; i++) begin
         v_or = v_or | (v1_ff[i][V_W-1] ? V_W'(-v1_ff[i]) : V_W'(v1_ff[i]));
      end
      bl1   = bit_len(64'(v_or));
      s1_in = (bl1 > 7'(PRE_LIMIT)) ? bl1 - 7'(PRE_LIMIT) : '0;
   end

   // Stage 3: pre-scale shift.
   logic signed [VS_W-1:0] vs3_in [3];
   logic signed [VS_W-1:0] vs3_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vs3_in[i] = VS_W'(v2_ff[i] >>> s1_ff);
      end
   end

   // Stage 4: first cross product.
   logic signed [C_W-1:0]  c4_in [3];
   logic signed [C_W-1:0]  c4_ff [3];
   logic signed [VS_W-1:0] vs4_ff [3];

   always_comb begin
      c4_in[0] = C_W'(quat_y_ff * vs3_ff[2]) - C_W'(quat_z_ff * vs3_ff[1]);
      c4_in[1] = C_W'(quat_z_ff * vs3_ff[0]) - C_W'(quat_x_ff * vs3_ff[2]);
      c4_in[2] = C_W'(quat_x_ff * vs3_ff[1]) - C_W'(quat_y_ff * vs3_ff[0]);
   end

   // Stage 5: second cross product and real-part term.
   logic signed [CC_W-1:0] wc5_in [3], cc5_in [3];
   logic signed [CC_W-1:0] wc5_ff [3], cc5_ff [3];
   logic signed [VS_W-1:0] vs5_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wc5_in[i] = CC_W'(quat_w_ff * c4_ff[i]);
      end
      cc5_in[0] = CC_W'(quat_y_ff * c4_ff[2]) - CC_W'(quat_z_ff * c4_ff[1]);
      cc5_in[1] = CC_W'(quat_z_ff * c4_ff[0]) - CC_W'(quat_x_ff * c4_ff[2]);
      cc5_in[2] = CC_W'(quat_x_ff * c4_ff[1]) - CC_W'(quat_y_ff * c4_ff[0]);
   end

   // Stage 6: rotated vector.
   logic signed [R_W-1:0] r6_in [3];
   logic signed [R_W-1:0] r6_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r6_in[i] = (R_W'(vs5_ff[i]) <<< ROT_SHIFT)
                  + ((R_W'(wc5_ff[i]) + R_W'(cc5_ff[i])) <<< 1);
      end
   end

   // Stage 7: zero test and post-scale amount.
   logic [R_W-1:0] r_or;
   logic [6:0]     bl2;
   logic [6:0]     s2_in, s2_ff;
   logic           degen7_in, degen7_ff;
   logic signed [R_W-1:0] r7_ff [3];

   always_comb begin
      r_or = '0;
      for (int i = 0; i < 3; i++) begin
         r_or = r_or | (r6_ff[i][R_W-1] ? R_W'(-r6_ff[i]) : R_W'(r6_ff[i]));
      end
      degen7_in = (r_or == '0);
      bl2       = bit_len(r_or);
      s2_in     = (bl2 > 7'(POST_LIMIT)) ? bl2 - 7'(POST_LIMIT) : '0;
   end

   // Stage 8: post-scale shift, split into sign and magnitude.
   logic signed [crd_pkg::MAG_W-1:0] rs8 [3];
   crd_pkg::ray_side_type side8_in, side8_ff;

   always_comb begin
      side8_in.degen = degen7_ff;
      for (int i = 0; i < 3; i++) begin
         rs8[i]           = crd_pkg::MAG_W'(r7_ff[i] >>> s2_ff);
         side8_in.neg[i]  = rs8[i][crd_pkg::MAG_W-1];
         side8_in.mag[i]  = rs8[i][crd_pkg::MAG_W-1] ? crd_pkg::MAG_W'(-rs8[i])
                                                      : crd_pkg::MAG_W'(rs8[i]);
      end
   end

   // Stage 9: squares.
   logic [SQ_W-1:0] sq9_in [3];
   logic [SQ_W-1:0] sq9_ff [3];
   crd_pkg::ray_side_type side9_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq9_in[i] = SQ_W'(side8_ff.mag[i]) * SQ_W'(side8_ff.mag[i]);
      end
   end

   // Stage 10: sum of squares.
   logic [crd_pkg::SUM_W-1:0] sum10_in, sum10_ff;
   crd_pkg::ray_side_type     side10_ff;

   assign sum10_in = crd_pkg::SUM_W'(sq9_ff[0]) + crd_pkg::SUM_W'(sq9_ff[1])
                   + crd_pkg::SUM_W'(sq9_ff[2]);

   always_ff @(posedge clock) begin
      if (advance) begin
         v1_ff     <= v1_in;
         s1_ff     <= s1_in;
         v2_ff     <= v1_ff;
         vs3_ff    <= vs3_in;
         c4_ff     <= c4_in;
         vs4_ff    <= vs3_ff;
         wc5_ff    <= wc5_in;
         cc5_ff    <= cc5_in;
         vs5_ff    <= vs4_ff;
         r6_ff     <= r6_in;
         s2_ff     <= s2_in;
         degen7_ff <= degen7_in;
         r7_ff     <= r6_ff;
         side8_ff  <= side8_in;
         sq9_ff    <= sq9_in;
         side9_ff  <= side8_ff;
         sum10_ff  <= sum10_in;
         side10_ff <= side9_ff;
      end
   end

   logic                      root_valid;
   logic [crd_pkg::LEN_W-1:0] root_len;
   crd_pkg::ray_side_type     root_side;

   crd_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pv_ff[10]),
      .in_sum    (sum10_ff),
      .in_side   (side10_ff),
      .out_valid (root_valid),
      .out_root  (root_len),
      .out_side  (root_side)
   );

   logic                                          quo_valid;
   logic [crd_pkg::COMPS-1:0][crd_pkg::QUO_W-1:0] quo;
   crd_pkg::ray_side_type                         quo_side;

   crd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (root_valid),
      .in_len    (root_len),
      .in_side   (root_side),
      .out_valid (quo_valid),
      .out_quo   (quo),
      .out_side  (quo_side)
   );

   logic signed [crd_pkg::DIR_W-1:0] dir_in [3];
   logic signed [crd_pkg::DIR_W-1:0] dir_ff [3];
   logic                             degen_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (quo_side.degen) begin
            dir_in[i] = '0;
         end else if (quo_side.neg[i]) begin
            dir_in[i] = -$signed(crd_pkg::DIR_W'(quo[i]));
         end else begin
            dir_in[i] = $signed(crd_pkg::DIR_W'(quo[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= quo_valid;
      end
      if (advance) begin
         dir_ff   <= dir_in;
         degen_ff <= quo_side.degen;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dir_x      = dir_ff[0];
   assign rsp_dir_y      = dir_ff[1];
   assign rsp_dir_z      = dir_ff[2];
   assign rsp_degenerate = degen_ff;
   assign rsp_ray_origin = origin_ff;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the camera ray direction core, with its own bit-exact ray predictor.
`timescale 1ns / 100ps

module testbench;

   localparam int FRAC = 15;
   localparam int LATENCY = 58;
   localparam longint CYCLE_LIMIT = 600000;

   typedef enum logic [2:0] {
      REG_QUAT_W = 3'd0, REG_QUAT_X = 3'd1, REG_QUAT_Y = 3'd2, REG_QUAT_Z = 3'd3,
      REG_FOCAL = 3'd4, REG_ASPECT = 3'd5, REG_ORIGIN = 3'd6, REG_UNUSED = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [15:0] u;
      logic [15:0] v;
   } coord_type;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic [47:0]        origin;
      logic               degenerate;
   } ray_type;

   typedef longint vec3_type [3];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_u = '0;
   logic [15:0] req_v = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic [47:0] rsp_ray_origin;
   logic rsp_degenerate;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [47:0] csr_data = '0;

   logic signed [15:0] cam_qw, cam_qx, cam_qy, cam_qz;
   logic [15:0] cam_focal, cam_aspect;
   logic [47:0] cam_origin;

   coord_type pending_coords[$];
   ray_type   expected_rays[$];
   int     send_gap = 0;
   int     stall_left = 0;
   int     hold_left = 0;
   logic   hold_go = 1'b0;
   logic   hold_done = 1'b0;
   int     failures = 0;
   longint cycles = 0;

   camera_ray_direction_core #(.COORD_FRAC_BITS(FRAC)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned magnitude(longint x);
      return x < 0 ? longint'(-x) : x;
   endfunction

   function automatic vec3_type shrink_vec(vec3_type a, int limit_bits);
      longint unsigned m;
      int s;
      m = magnitude(a[0]);
      s = 0;
      if (magnitude(a[1]) > m) m = magnitude(a[1]);
      if (magnitude(a[2]) > m) m = magnitude(a[2]);
      while (s < 63 && (m >> s) >= (64'd1 << limit_bits)) s++;
      for (int i = 0; i < 3; i++) a[i] = a[i] >>> s;
      return a;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic ray_type predict_ray(coord_type c_in);
      ray_type ray;
      longint one, px, py, qw, qx, qy, qz;
      longint unsigned len, quo;
      vec3_type vec, c, cc, r;
      longint d;
      one = 64'sd1 <<< FRAC;
      px = 2 * longint'({48'd0, c_in.u}) - one;
      py = 2 * longint'({48'd0, c_in.v}) - one;
      qw = longint'(cam_qw);
      qx = longint'(cam_qx);
      qy = longint'(cam_qy);
      qz = longint'(cam_qz);
      vec[0] = -(px * longint'({48'd0, cam_aspect}));
      vec[1] = -(py * 256);
      vec[2] = longint'({48'd0, cam_focal}) * one;
      vec = shrink_vec(vec, 24);
      c[0] = qy * vec[2] - qz * vec[1];
      c[1] = qz * vec[0] - qx * vec[2];
      c[2] = qx * vec[1] - qy * vec[0];
      cc[0] = qy * c[2] - qz * c[1];
      cc[1] = qz * c[0] - qx * c[2];
      cc[2] = qx * c[1] - qy * c[0];
      for (int i = 0; i < 3; i++) r[i] = vec[i] * (64'sd1 <<< 28) + 2 * (qw * c[i] + cc[i]);
      ray.origin = cam_origin;
      if (r[0] == 0 && r[1] == 0 && r[2] == 0) begin
         ray.dir_x = '0;
         ray.dir_y = '0;
         ray.dir_z = '0;
         ray.degenerate = 1'b1;
         return ray;
      end
      r = shrink_vec(r, 30);
      len = int_sqrt(magnitude(r[0]) * magnitude(r[0]) + magnitude(r[1]) * magnitude(r[1])
                     + magnitude(r[2]) * magnitude(r[2]));
      for (int i = 0; i < 3; i++) begin
         quo = (magnitude(r[i]) * 16384 + len / 2) / len;
         d = r[i] < 0 ? -longint'(quo) : longint'(quo);
         if (i == 0) ray.dir_x = d[15:0];
         else if (i == 1) ray.dir_y = d[15:0];
         else ray.dir_z = d[15:0];
      end
      ray.degenerate = 1'b0;
      return ray;
   endfunction

   function automatic int random_gap();
      int p;
      p = $urandom_range(99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Sender: a payload stays put while the core stalls its transfer.
   always @(posedge clock) begin
      if (!reset && (!req_valid || !req_stall)) begin
         if (req_valid) begin
            expected_rays.push_back(predict_ray(pending_coords[0]));
            void'(pending_coords.pop_front());
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_coords.size() > 0) begin
            req_valid <= 1'b1;
            req_u <= pending_coords[0].u;
            req_v <= pending_coords[0].v;
            send_gap <= random_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: checks each transfer and stalls at random, once for a long stretch.
   always @(posedge clock) begin
      ray_type exp_ray;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rays.size() == 0) begin
            $error("response with no ray expected");
            failures++;
         end else begin
            exp_ray = expected_rays.pop_front();
            if (rsp_dir_x !== exp_ray.dir_x) begin
               $error("dir_x expected %0d actual %0d", exp_ray.dir_x, rsp_dir_x);
               failures++;
            end
            if (rsp_dir_y !== exp_ray.dir_y) begin
               $error("dir_y expected %0d actual %0d", exp_ray.dir_y, rsp_dir_y);
               failures++;
            end
            if (rsp_dir_z !== exp_ray.dir_z) begin
               $error("dir_z expected %0d actual %0d", exp_ray.dir_z, rsp_dir_z);
               failures++;
            end
            if (rsp_ray_origin !== exp_ray.origin) begin
               $error("ray_origin expected %h actual %h", exp_ray.origin, rsp_ray_origin);
               failures++;
            end
            if (rsp_degenerate !== exp_ray.degenerate) begin
               $error("degenerate expected %0d actual %0d", exp_ray.degenerate,
                      rsp_degenerate);
               failures++;
            end
         end
      end
      if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left <= random_gap();
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_reg(reg_index_type idx, logic [47:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         REG_QUAT_W: cam_qw = value[15:0];
         REG_QUAT_X: cam_qx = value[15:0];
         REG_QUAT_Y: cam_qy = value[15:0];
         REG_QUAT_Z: cam_qz = value[15:0];
         REG_FOCAL:  cam_focal = value[15:0];
         REG_ASPECT: cam_aspect = value[15:0];
         REG_ORIGIN: cam_origin = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      while (pending_coords.size() != 0 || expected_rays.size() != 0 || req_valid)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic push_coord(logic [15:0] u, logic [15:0] v);
      coord_type c_new;
      c_new.u = u;
      c_new.v = v;
      pending_coords.push_back(c_new);
   endtask

   function automatic logic [15:0] random_quat(int mode);
      if (mode == 0) return 16'(-16384);
      if (mode == 1) return 16'd16384;
      if ($urandom_range(9) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   task automatic random_config(int phase);
      int mode;
      mode = $urandom_range(5);
      write_reg(REG_QUAT_W, {32'd0, random_quat(mode)});
      write_reg(REG_QUAT_X, {32'd0, random_quat(mode)});
      write_reg(REG_QUAT_Y, {32'd0, random_quat(mode)});
      write_reg(REG_QUAT_Z, {32'd0, random_quat(mode)});
      write_reg(REG_FOCAL, phase == 1 ? 48'd65535 : phase == 2 ? 48'd1 :
                48'($urandom_range(65535)));
      write_reg(REG_ASPECT, phase == 1 ? 48'd65535 : phase == 2 ? 48'd1 :
                48'($urandom_range(65535, 1)));
      write_reg(REG_ORIGIN, 48'({$urandom, $urandom}));
      if ($urandom_range(1)) write_reg(REG_UNUSED, 48'({$urandom, $urandom}));
   endtask

   function automatic logic [15:0] random_coord();
      int p;
      p = $urandom_range(19);
      if (p == 0) return 16'($urandom);
      if (p == 1) return 16'd0;
      if (p == 2) return 16'd32768;
      return 16'($urandom_range(32768));
   endfunction

   initial begin
      cam_qw = 16'sd16384;
      cam_qx = '0;
      cam_qy = '0;
      cam_qz = '0;
      cam_focal = 16'd256;
      cam_aspect = 16'd256;
      cam_origin = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset orientation: corners, centre and coordinates beyond 1.0.
      push_coord(16'd0, 16'd0);
      push_coord(16'd32768, 16'd32768);
      push_coord(16'd0, 16'd32768);
      push_coord(16'd32768, 16'd0);
      push_coord(16'd16384, 16'd16384);
      push_coord(16'd65535, 16'd65535);
      push_coord(16'd65535, 16'd0);
      push_coord(16'd1, 16'd32767);
      drain();

      // Zero focal length and aspect: the centre gives a degenerate ray.
      write_reg(REG_FOCAL, 48'd0);
      write_reg(REG_ASPECT, 48'd0);
      write_reg(REG_ORIGIN, 48'hFFFF_8000_7FFF);
      write_reg(REG_UNUSED, 48'h1234);
      push_coord(16'd16384, 16'd16384);
      push_coord(16'd0, 16'd16384);
      push_coord(16'd16384, 16'd0);
      push_coord(16'd32768, 16'd32768);
      drain();

      // Zero quaternion with extreme focal length, then a quaternion whose four parts are all plus or minus 16384.
      write_reg(REG_QUAT_W, 48'd0);
      write_reg(REG_FOCAL, 48'd65535);
      write_reg(REG_ASPECT, 48'd65535);
      push_coord(16'd16384, 16'd16384);
      push_coord(16'd0, 16'd65535);
      push_coord(16'd32768, 16'd0);
      drain();
      write_reg(REG_QUAT_W, 48'(16'(-16384)));
      write_reg(REG_QUAT_X, 48'd16384);
      write_reg(REG_QUAT_Y, 48'(16'(-16384)));
      write_reg(REG_QUAT_Z, 48'd16384);
      push_coord(16'd0, 16'd0);
      push_coord(16'd32768, 16'd32768);
      push_coord(16'd12345, 16'd23456);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         random_config(phase);
         for (int i = 0; i < 200; i++) push_coord(random_coord(), random_coord());
         if (phase == 3) begin
            @(posedge clock);
            hold_go <= 1'b1;
         end
         drain();
      end

      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
